// File: design/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and helpers of the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int CW   = 32;       // coordinate width, Q16.16
  localparam int UFB  = 14;       // unit fraction bits
  localparam int UW   = 16;       // unit entry width, Q1.14
  localparam int DW   = CW + 1;   // eye minus focal
  localparam int VW   = 48;       // vector width into the normalizer
  localparam int LIMW = 16;       // zero length limit width
  localparam int SW   = 30;       // normalized magnitude bits

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [VW-1:0] wide_t;

  typedef coord_t [2:0] cvec_t;
  typedef diff_t  [2:0] dvec_t;
  typedef unit_t  [2:0] uvec_t;
  typedef wide_t  [2:0] wvec_t;

  typedef struct packed {
    cvec_t      e;
    dvec_t      d;
    cvec_t      up;
    cvec_t      us;
    logic [1:0] s;
    logic       small_d;
    logic       small_up;
  } item_t;

  typedef struct packed {
    logic  start;
    wvec_t v;
  } norm_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    uvec_t u;
  } norm_rsp_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SHIFT, NS_SQ, NS_SQRT, NS_DSET, NS_DIV, NS_DONE
  } norm_state_e;

  typedef enum logic [3:0] {
    BS_IDLE, BS_WAIT_V, BS_WAIT_N2, BS_CROSS_U, BS_WAIT_N1, BS_CROSS_P,
    BS_TEST, BS_WAIT_U, BS_CROSS_V, BS_DOT, BS_OUT
  } back_state_e;

  function automatic wide_t ext_c(coord_t c);
    ext_c = {{(VW-CW){c[CW-1]}}, c};
  endfunction

  function automatic wide_t ext_d(diff_t c);
    ext_d = {{(VW-DW){c[DW-1]}}, c};
  endfunction

  function automatic wide_t ext_u(unit_t c);
    ext_u = {{(VW-UW){c[UW-1]}}, c};
  endfunction

  function automatic logic [VW-1:0] mag_w(wide_t x);
    mag_w = x[VW-1] ? VW'(-x) : VW'(x);
  endfunction

  // any magnitude of 256 or more already exceeds every 16-bit limit
  function automatic logic is_small(logic [VW-1:0] m0, logic [VW-1:0] m1,
                                    logic [VW-1:0] m2, logic [LIMW-1:0] lim);
    logic        big;
    logic [17:0] sum;
    big = (|m0[VW-1:8]) || (|m1[VW-1:8]) || (|m2[VW-1:8]);
    sum = 18'(m0[7:0]) * 18'(m0[7:0]) + 18'(m1[7:0]) * 18'(m1[7:0])
        + 18'(m2[7:0]) * 18'(m2[7:0]);
    is_small = !big && (sum <= 18'(lim));
  endfunction

  function automatic uvec_t perp_axis(uvec_t a);
    logic [UW-1:0] ax, ay, az;
    uvec_t         p;
    ax = a[0][UW-1] ? UW'(-$signed(a[0])) : UW'(a[0]);
    ay = a[1][UW-1] ? UW'(-$signed(a[1])) : UW'(a[1]);
    az = a[2][UW-1] ? UW'(-$signed(a[2])) : UW'(a[2]);
    if (ax < ay && ax < az) begin
      p[0] = '0; p[1] = -$signed(a[2]); p[2] = a[1];
    end else if (ax < ay) begin
      p[0] = -$signed(a[1]); p[1] = a[0]; p[2] = '0;
    end else if (ay < az) begin
      p[0] = a[2]; p[1] = '0; p[2] = -$signed(a[0]);
    end else begin
      p[0] = -$signed(a[1]); p[1] = a[0]; p[2] = '0;
    end
    perp_axis = p;
  endfunction

endpackage

`default_nettype wire

// File: design/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at camera basis and translation from eye, focal and up points.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; a two-deep queue sits
// in front of the back end, so busy rises only when two words wait. Each
// result is shown for one cycle with done_o and cannot be held off. A word
// skips the shared normalizer when both eye-focal and up are zero length
// and uses it twice otherwise; the normalizer runs a prescale, a 31-step
// square root and 15-step dividers.
`default_nettype none

module look_at_view_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] focal_x_i,
  input  logic signed [31:0] focal_y_i,
  input  logic signed [31:0] focal_z_i,
  input  logic signed [31:0] upvec_x_i,
  input  logic signed [31:0] upvec_y_i,
  input  logic signed [31:0] upvec_z_i,
  output logic        done_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] true_up_x_o,
  output logic signed [15:0] true_up_y_o,
  output logic signed [15:0] true_up_z_o,
  output logic signed [15:0] back_x_o,
  output logic signed [15:0] back_y_o,
  output logic signed [15:0] back_z_o,
  output logic signed [31:0] shift_x_o,
  output logic signed [31:0] shift_y_o,
  output logic signed [31:0] shift_z_o
);
  import lav_pkg::*;

  logic [LIMW-1:0] limit_q;
  cvec_t           eye, focal, upv, shv;
  item_t           head;
  logic            head_valid, pop;
  norm_req_t       nreq;
  norm_rsp_t       nrsp;
  uvec_t           ru, rv, rn;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-LIMW){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMW'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      limit_q <= pwdata[LIMW-1:0];
    end
  end

  assign eye   = {eye_z_i, eye_y_i, eye_x_i};
  assign focal = {focal_z_i, focal_y_i, focal_x_i};
  assign upv   = {upvec_z_i, upvec_y_i, upvec_x_i};

  lav_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .eye_i        (eye),
    .focal_i      (focal),
    .upvec_i      (upv),
    .limit_i      (limit_q),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  lav_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  lav_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .norm_req_o   (nreq),
    .norm_rsp_i   (nrsp),
    .done_o       (done_o),
    .right_o      (ru),
    .true_up_o    (rv),
    .back_o       (rn),
    .shift_o      (shv)
  );

  assign right_x_o   = ru[0];
  assign right_y_o   = ru[1];
  assign right_z_o   = ru[2];
  assign true_up_x_o = rv[0];
  assign true_up_y_o = rv[1];
  assign true_up_z_o = rv[2];
  assign back_x_o    = rn[0];
  assign back_y_o    = rn[1];
  assign back_z_o    = rn[2];
  assign shift_x_o   = shv[0];
  assign shift_y_o   = shv[1];
  assign shift_z_o   = shv[2];

endmodule

`default_nettype wire

// File: design/lav_front.sv
// ----------------------------------------------------------------------------
// lav_front
// Accepts words, forms eye minus focal and the scaled up vector, runs the
// zero length tests and queues the word two deep for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  lav_pkg::cvec_t         eye_i,
  input  lav_pkg::cvec_t         focal_i,
  input  lav_pkg::cvec_t         upvec_i,
  input  logic [lav_pkg::LIMW-1:0] limit_i,
  output logic                   head_valid_o,
  output lav_pkg::item_t         head_o,
  input  logic                   pop_i
);
  import lav_pkg::*;

  item_t           item;
  logic [VW-1:0]   dm [3];
  logic [VW-1:0]   um [3];
  logic [VW-1:0]   ush [3];
  logic            hi2, hi1;

  item_t           mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            push;

  always_comb begin
    hi2 = 1'b0;
    hi1 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      item.e[i]  = eye_i[i];
      item.up[i] = upvec_i[i];
      item.d[i]  = $signed({eye_i[i][CW-1], eye_i[i]}) - $signed({focal_i[i][CW-1], focal_i[i]});
      dm[i] = mag_w(ext_d(item.d[i]));
      um[i] = mag_w(ext_c(upvec_i[i]));
      hi2 = hi2 | um[i][CW-1];
      hi1 = hi1 | um[i][CW-2];
    end
    item.s = hi2 ? 2'd2 : (hi1 ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      ush[i] = um[i] >> item.s;
      item.us[i] = upvec_i[i][CW-1] ? CW'(-$signed(ush[i])) : CW'(ush[i]);
    end
    item.small_d  = is_small(dm[0], dm[1], dm[2], limit_i);
    item.small_up = is_small(um[0], um[1], um[2], limit_i);
  end

  assign busy         = (cnt_q == 2'd2);
  assign push         = start && !busy;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

endmodule

`default_nettype wire

// File: design/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Iterative vector normalizer: power-of-two prescale one bit a cycle,
// squared length on one multiplier, digit-serial square root and three
// restoring dividers for the unit entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lav_pkg::norm_req_t req_i,
  output lav_pkg::norm_rsp_t rsp_o
);
  import lav_pkg::*;

  localparam int QW = UFB + 1;        // quotient bits
  localparam int XW = 2 * SW + 2;     // squared length
  localparam int LW = SW + 1;         // length
  localparam int RW = LW + 1;         // divider remainder
  localparam int NW = SW + QW + 1;    // dividend
  localparam logic [XW-1:0] BIT0 = XW'(1) << (2 * SW);

  norm_state_e     state_q, state_d;
  logic [VW-1:0]   m_q [3];
  logic [VW-1:0]   in_mag [3];
  logic [2:0]      neg_q;
  logic [3:0]      cnt_q;
  logic [XW-1:0]   x_q, r_q, bit_q, rb;
  logic [RW-1:0]   rem_q [3];
  logic [QW-1:0]   lo_q [3];
  logic [QW-1:0]   q_q [3];
  logic            any_hi, any_top, all_zero, take;
  logic [LW-1:0]   len;
  logic [RW-1:0]   dvs;
  logic [NW-1:0]   nv [3];
  logic [RW:0]     dt [3];
  logic [2:0]      ge;
  logic [2*SW-1:0] sq_term;

  always_comb begin
    any_hi   = 1'b0;
    any_top  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = mag_w(req_i.v[i]);
      all_zero  = all_zero && (in_mag[i] == '0);
      any_hi    = any_hi || (|m_q[i][VW-1:SW]);
      any_top   = any_top || m_q[i][SW-1];
    end
    take    = req_i.start && (state_q == NS_IDLE || state_q == NS_DONE);
    sq_term = m_q[cnt_q[1:0]][SW-1:0] * m_q[cnt_q[1:0]][SW-1:0];
    rb      = r_q + bit_q;
    len     = r_q[LW-1:0];
    dvs     = {len, 1'b0};
    for (int i = 0; i < 3; i++) begin
      nv[i] = {m_q[i][SW-1:0], {QW{1'b0}}} + NW'(len);
      dt[i] = {rem_q[i], lo_q[i][QW-1]};
      ge[i] = (dt[i] >= {1'b0, dvs});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NS_IDLE, NS_DONE: begin
        if (take) state_d = all_zero ? NS_DONE : NS_SHIFT;
        else      state_d = NS_IDLE;
      end
      NS_SHIFT: if (!any_hi && any_top) state_d = NS_SQ;
      NS_SQ:    if (cnt_q == 4'd2) state_d = NS_SQRT;
      NS_SQRT:  if (bit_q[0]) state_d = NS_DSET;
      NS_DSET:  state_d = NS_DIV;
      NS_DIV:   if (cnt_q == 4'(QW - 1)) state_d = NS_DONE;
      default:  state_d = NS_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = !(state_q == NS_IDLE || state_q == NS_DONE);
    rsp_o.done = (state_q == NS_DONE);
    for (int i = 0; i < 3; i++) begin
      rsp_o.u[i] = neg_q[i] ? -$signed(UW'(q_q[i])) : $signed(UW'(q_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= NS_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      NS_IDLE, NS_DONE: begin
        if (take) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= in_mag[i];
            neg_q[i] <= req_i.v[i][VW-1];
            q_q[i]   <= '0;
          end
        end
      end
      NS_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (any_hi)        m_q[i] <= m_q[i] >> 1;
          else if (!any_top) m_q[i] <= m_q[i] << 1;
        end
        x_q   <= '0;
        cnt_q <= '0;
      end
      NS_SQ: begin
        x_q   <= x_q + XW'(sq_term);
        cnt_q <= cnt_q + 4'd1;
        bit_q <= BIT0;
        r_q   <= '0;
      end
      NS_SQRT: begin
        if (x_q >= rb) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      NS_DSET: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= RW'(nv[i][NW-1:QW]);
          lo_q[i]  <= nv[i][QW-1:0];
        end
        cnt_q <= '0;
      end
      NS_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= ge[i] ? RW'(dt[i] - {1'b0, dvs}) : RW'(dt[i]);
          lo_q[i]  <= lo_q[i] << 1;
          q_q[i]   <= {q_q[i][QW-2:0], ge[i]};
        end
        cnt_q <= cnt_q + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/lav_back.sv
// ----------------------------------------------------------------------------
// lav_back
// Sequencer that builds the basis from a queued word: normalizer requests,
// cross products one entry a cycle, translation dots one product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lav_pkg::LIMW-1:0] limit_i,
  input  logic                     head_valid_i,
  input  lav_pkg::item_t           head_i,
  output logic                     pop_o,
  output lav_pkg::norm_req_t       norm_req_o,
  input  lav_pkg::norm_rsp_t       norm_rsp_i,
  output logic                     done_o,
  output lav_pkg::uvec_t           right_o,
  output lav_pkg::uvec_t           true_up_o,
  output lav_pkg::uvec_t           back_o,
  output lav_pkg::cvec_t           shift_o
);
  import lav_pkg::*;

  localparam int PW = CW + UW;        // one product
  localparam int AW = PW + 2;         // dot accumulator
  localparam int TW = AW - UFB;       // dot in Q20.16
  localparam logic [UW-1:0] ONE = UW'(1) << UFB;

  back_state_e     state_q, state_d;
  item_t           it_q;
  uvec_t           u_q, v_q, n_q, ru_q, rv_q, rn_q;
  wvec_t           p_q;
  cvec_t           sh_q, so_q;
  logic [1:0]      k_q, dv_q, dc_q;
  logic            done_q;
  logic [AW-1:0]   acc_q;

  logic signed [CW-1:0] ca [3];
  logic signed [UW-1:0] cb [3];
  logic [1:0]           i1, i2;
  logic signed [PW-1:0] pa, pb;
  logic signed [PW:0]   cprod;
  logic [PW:0]          cmag;
  logic [PW:0]          crnd;
  logic [UW-1:0]        cclp;
  unit_t                cunit;
  logic [VW-1:0]        urm [3];
  logic [4:0]           ursh;
  logic                 ur_small;
  uvec_t                pn, pv;
  unit_t                dsel;
  logic signed [PW-1:0] dprod;
  logic [AW-1:0]        dsum;
  logic [TW:0]          nt;
  coord_t               tsat;

  // cross product entry k: a[k+1]*b[k+2] - a[k+2]*b[k+1]
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (state_q)
        BS_CROSS_P: begin
          ca[i] = it_q.us[i];
          cb[i] = n_q[i];
        end
        BS_CROSS_V: begin
          ca[i] = CW'($signed(n_q[i]));
          cb[i] = u_q[i];
        end
        default: begin
          ca[i] = CW'($signed(v_q[i]));
          cb[i] = n_q[i];
        end
      endcase
    end
    unique case (k_q)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    pa    = ca[i1] * cb[i2];
    pb    = ca[i2] * cb[i1];
    cprod = $signed({pa[PW-1], pa}) - $signed({pb[PW-1], pb});
    cmag  = cprod[PW] ? (PW+1)'(-cprod) : (PW+1)'(cprod);
    crnd  = (cmag + ((PW+1)'(1) << (UFB - 1))) >> UFB;
    cclp  = (crnd > (PW+1)'(ONE)) ? ONE : UW'(crnd);
    cunit = cprod[PW] ? -$signed(cclp) : $signed(cclp);
  end

  always_comb begin
    ursh = 5'(UFB) - {3'b000, it_q.s};
    for (int i = 0; i < 3; i++) urm[i] = mag_w(p_q[i]) >> ursh;
    ur_small = is_small(urm[0], urm[1], urm[2], limit_i);
    pn       = perp_axis(n_q);
    pv       = perp_axis(norm_rsp_i.u);
  end

  always_comb begin
    unique case (dv_q)
      2'd0:    dsel = u_q[dc_q];
      2'd1:    dsel = v_q[dc_q];
      default: dsel = n_q[dc_q];
    endcase
    dprod = dsel * $signed(it_q.e[dc_q]);
    dsum  = acc_q + AW'(dprod);
    nt    = -$signed({dsum[AW-1], dsum[AW-1:UFB]});
    if (nt[TW:CW-1] != {(TW-CW+2){nt[TW]}}) tsat = nt[TW] ? {1'b1, {(CW-1){1'b0}}}
                                                          : {1'b0, {(CW-1){1'b1}}};
    else tsat = nt[CW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (head_valid_i) begin
          if (head_i.small_d && head_i.small_up) state_d = BS_DOT;
          else if (head_i.small_d)               state_d = BS_WAIT_V;
          else                                   state_d = BS_WAIT_N1;
        end
      end
      BS_WAIT_V:  if (norm_rsp_i.done) state_d = BS_WAIT_N2;
      BS_WAIT_N2: if (norm_rsp_i.done) state_d = BS_CROSS_U;
      BS_WAIT_N1: if (norm_rsp_i.done) state_d = BS_CROSS_P;
      BS_WAIT_U:  if (norm_rsp_i.done) state_d = BS_CROSS_V;
      BS_CROSS_U: if (k_q == 2'd2) state_d = BS_DOT;
      BS_CROSS_V: if (k_q == 2'd2) state_d = BS_DOT;
      BS_CROSS_P: if (k_q == 2'd2) state_d = BS_TEST;
      BS_TEST:    state_d = BS_WAIT_U;
      BS_DOT:     if (dv_q == 2'd2 && dc_q == 2'd2) state_d = BS_OUT;
      BS_OUT:     state_d = BS_IDLE;
      default:    state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    norm_req_o = '0;
    unique case (state_q)
      BS_IDLE: begin
        if (head_valid_i) begin
          pop_o            = 1'b1;
          norm_req_o.start = !(head_i.small_d && head_i.small_up);
          for (int i = 0; i < 3; i++) begin
            norm_req_o.v[i] = head_i.small_d ? ext_c(head_i.up[i]) : ext_d(head_i.d[i]);
          end
        end
      end
      BS_WAIT_V: begin
        norm_req_o.start = norm_rsp_i.done;
        for (int i = 0; i < 3; i++) norm_req_o.v[i] = ext_u(pv[i]);
      end
      BS_TEST: begin
        norm_req_o.start = 1'b1;
        for (int i = 0; i < 3; i++) norm_req_o.v[i] = ur_small ? ext_u(pn[i]) : p_q[i];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      k_q     <= '0;
      dv_q    <= '0;
      dc_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == BS_OUT);
      if (state_q == BS_CROSS_U || state_q == BS_CROSS_V || state_q == BS_CROSS_P) begin
        k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      if (state_q == BS_DOT) begin
        if (dc_q == 2'd2) begin
          dc_q <= 2'd0;
          dv_q <= (dv_q == 2'd2) ? 2'd0 : dv_q + 2'd1;
        end else begin
          dc_q <= dc_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        if (head_valid_i) begin
          it_q <= head_i;
          for (int i = 0; i < 3; i++) begin
            u_q[i] <= (i == 0) ? ONE : '0;
            v_q[i] <= (i == 1) ? ONE : '0;
            n_q[i] <= (i == 2) ? ONE : '0;
          end
        end
        acc_q <= '0;
      end
      BS_WAIT_V:  if (norm_rsp_i.done) v_q <= norm_rsp_i.u;
      BS_WAIT_N2: if (norm_rsp_i.done) n_q <= norm_rsp_i.u;
      BS_WAIT_N1: if (norm_rsp_i.done) n_q <= norm_rsp_i.u;
      BS_WAIT_U:  if (norm_rsp_i.done) u_q <= norm_rsp_i.u;
      BS_CROSS_U: u_q[k_q] <= cunit;
      BS_CROSS_V: v_q[k_q] <= cunit;
      BS_CROSS_P: p_q[k_q] <= cprod[VW-1:0];
      BS_DOT: begin
        if (dc_q == 2'd2) begin
          sh_q[dv_q] <= tsat;
          acc_q      <= '0;
        end else begin
          acc_q <= dsum;
        end
      end
      BS_OUT: begin
        ru_q <= u_q;
        rv_q <= v_q;
        rn_q <= n_q;
        so_q <= sh_q;
      end
      default: ;
    endcase
  end

  assign done_o    = done_q;
  assign right_o   = ru_q;
  assign true_up_o = rv_q;
  assign back_o    = rn_q;
  assign shift_o   = so_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_norm_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_req_o.start |-> !norm_rsp_i.busy) else $error("normalizer started while busy");
  a_pop_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q != BS_IDLE) else $error("word popped without being worked");
`endif

endmodule

`default_nettype wire
